[sv/csvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the CSV record tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] SEP_RESET  = 8'h2C;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNTERM      = 3'd1;
    localparam logic [2:0] ST_AFTER_QUOTE = 3'd2;
    localparam logic [2:0] ST_QUOTE_UNQ   = 3'd3;
    localparam logic [2:0] ST_MISMATCH    = 3'd4;

    localparam int FIELDS_OUT_W = 16;
    localparam int INDEX_OUT_W  = 32;

    typedef enum logic [2:0] {
        CLS_EOF,
        CLS_LINE,
        CLS_SEP,
        CLS_QUOTE,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] data_byte;
    } token_t;

    typedef struct packed {
        logic                    char_valid;
        logic [7:0]              char_out;
        logic                    field_end;
        logic                    record_end;
        logic [FIELDS_OUT_W-1:0] fields_in_record;
        logic                    stream_done;
        logic [2:0]              status;
        logic [INDEX_OUT_W-1:0]  record_index;
    } out_beat_t;

endpackage

[sv/csvt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_front
// Input side: accepts beats and classifies each byte into a token.
// ----------------------------------------------------------------------------
module csvt_front
    import csvt_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    input  logic [7:0] separator,
    output logic       push_valid,
    input  logic       push_ready,
    output token_t     push_data
);

    cls_t cls;

    // CR/LF win over separator, separator wins over quote
    always_comb begin
        if (s_data.end_of_input) begin
            cls = CLS_EOF;
        end else if (s_data.data_byte == CHAR_CR || s_data.data_byte == CHAR_LF) begin
            cls = CLS_LINE;
        end else if (s_data.data_byte == separator) begin
            cls = CLS_SEP;
        end else if (s_data.data_byte == CHAR_QUOTE) begin
            cls = CLS_QUOTE;
        end else begin
            cls = CLS_OTHER;
        end
    end

    assign s_ready              = push_ready;
    assign push_valid           = s_valid;
    assign push_data.cls        = cls;
    assign push_data.data_byte  = s_data.data_byte;

endmodule

[sv/csvt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_queue
// Two-entry token FIFO between the classifier and the parser.
// ----------------------------------------------------------------------------
module csvt_queue
    import csvt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push_valid,
    output logic   push_ready,
    input  token_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output token_t pop_data
);

    token_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[sv/csvt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvt_back
// Parser state machine: field/record marks, counters, sticky errors, and the
// registered result beat.
// ----------------------------------------------------------------------------
module csvt_back
    import csvt_pkg::*;
#(
    parameter int FIELD_COUNT_BITS  = 16,
    parameter int RECORD_COUNT_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      tok_valid,
    output logic      tok_ready,
    input  token_t    tok_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    typedef enum logic [2:0] {
        MODE_LINE,
        MODE_FSTART,
        MODE_QUOTED,
        MODE_QQ,
        MODE_UNQUOTED,
        MODE_DONE
    } mode_t;

    localparam logic [FIELD_COUNT_BITS-1:0]  FIELD_MAX  = '1;
    localparam logic [RECORD_COUNT_BITS-1:0] RECORD_MAX = '1;

    mode_t                        mode_reg;
    mode_t                        mode_next;
    logic [FIELD_COUNT_BITS-1:0]  field_cnt_reg;
    logic [FIELD_COUNT_BITS-1:0]  field_cnt_next;
    logic [FIELD_COUNT_BITS-1:0]  expected_reg;
    logic                         expected_known_reg;
    logic [RECORD_COUNT_BITS-1:0] record_cnt_reg;
    logic [2:0]                   error_reg;
    logic [2:0]                   err;
    logic                         m_valid_reg;
    out_beat_t                    out_reg;
    out_beat_t                    out_next;
    logic                         cv;
    logic                         fe;
    logic                         re;
    logic                         blocked;
    logic                         pop;

    assign blocked   = (error_reg != ST_OK) || (mode_reg == MODE_DONE);
    assign tok_ready = !m_valid_reg || m_ready;
    assign pop       = tok_valid && tok_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        cv        = 1'b0;
        fe        = 1'b0;
        re        = 1'b0;
        err       = ST_OK;
        mode_next = mode_reg;
        case (mode_reg)
            MODE_LINE, MODE_FSTART: begin
                if (tok_data.cls == CLS_EOF || tok_data.cls == CLS_LINE) begin
                    if (mode_reg == MODE_FSTART) begin
                        fe = 1'b1;
                        re = 1'b1;
                    end
                    mode_next = (tok_data.cls == CLS_EOF) ? MODE_DONE : MODE_LINE;
                end else if (tok_data.cls == CLS_SEP) begin
                    fe        = 1'b1;
                    mode_next = MODE_FSTART;
                end else if (tok_data.cls == CLS_QUOTE) begin
                    mode_next = MODE_QUOTED;
                end else begin
                    cv        = 1'b1;
                    mode_next = MODE_UNQUOTED;
                end
            end
            MODE_QUOTED: begin
                if (tok_data.cls == CLS_EOF) begin
                    err = ST_UNTERM;
                end else if (tok_data.cls == CLS_QUOTE) begin
                    mode_next = MODE_QQ;
                end else begin
                    cv = 1'b1;
                end
            end
            MODE_QQ, MODE_UNQUOTED: begin
                if (tok_data.cls == CLS_EOF || tok_data.cls == CLS_LINE) begin
                    fe        = 1'b1;
                    re        = 1'b1;
                    mode_next = (tok_data.cls == CLS_EOF) ? MODE_DONE : MODE_LINE;
                end else if (tok_data.cls == CLS_SEP) begin
                    fe        = 1'b1;
                    mode_next = MODE_FSTART;
                end else if (tok_data.cls == CLS_QUOTE) begin
                    if (mode_reg == MODE_QQ) begin
                        cv        = 1'b1;
                        mode_next = MODE_QUOTED;
                    end else begin
                        err = ST_QUOTE_UNQ;
                    end
                end else begin
                    if (mode_reg == MODE_QQ) begin
                        err = ST_AFTER_QUOTE;
                    end else begin
                        cv = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (fe && field_cnt_reg != FIELD_MAX) begin
            field_cnt_next = field_cnt_reg + 1'b1;
        end else begin
            field_cnt_next = field_cnt_reg;
        end

        if (err == ST_OK && re && expected_known_reg && field_cnt_next != expected_reg) begin
            err = ST_MISMATCH;
        end

        out_next.char_valid       = 1'b0;
        out_next.char_out         = 8'd0;
        out_next.field_end        = 1'b0;
        out_next.record_end       = 1'b0;
        out_next.fields_in_record = FIELDS_OUT_W'(field_cnt_reg);
        out_next.stream_done      = (mode_reg == MODE_DONE);
        out_next.status           = error_reg;
        out_next.record_index     = INDEX_OUT_W'(record_cnt_reg);
        if (!blocked) begin
            if (err != ST_OK) begin
                out_next.status = err;
            end else begin
                out_next.char_valid       = cv;
                out_next.char_out         = cv ? tok_data.data_byte : 8'd0;
                out_next.field_end        = fe;
                out_next.record_end       = re;
                out_next.fields_in_record = FIELDS_OUT_W'(field_cnt_next);
                out_next.stream_done      = (mode_next == MODE_DONE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_LINE;
            field_cnt_reg      <= '0;
            expected_reg       <= '0;
            expected_known_reg <= 1'b0;
            record_cnt_reg     <= '0;
            error_reg          <= ST_OK;
            m_valid_reg        <= 1'b0;
        end else begin
            if (pop) begin
                m_valid_reg <= 1'b1;
                out_reg     <= out_next;
                if (!blocked) begin
                    if (err != ST_OK) begin
                        error_reg <= err;
                    end else begin
                        mode_reg <= mode_next;
                        if (re) begin
                            field_cnt_reg <= '0;
                            if (!expected_known_reg) begin
                                expected_reg       <= field_cnt_next;
                                expected_known_reg <= 1'b1;
                            end
                            if (record_cnt_reg != RECORD_MAX) begin
                                record_cnt_reg <= record_cnt_reg + 1'b1;
                            end
                        end else begin
                            field_cnt_reg <= field_cnt_next;
                        end
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/csv_record_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Byte-at-a-time CSV tokenizer with field/record marks and sticky errors.
//
// Input beats (s_valid/s_ready, s_data) carry one byte or an end-of-input
// mark. Each input beat produces exactly one result beat (m_valid/m_ready,
// m_data): an optional content byte, field-end and record-end marks, the
// field count of the current record, the record index and the status.
// The separator byte is written through cfg_we/cfg_wdata; write it only
// while idle, as the block itself does not enforce this. A taken input
// beat is stored in the token queue and then parsed into the result
// register. Throughput: one beat per cycle while m_ready is high.
// A two-entry token queue sits between classifier and parser, and the
// result register lets the next token be parsed in the cycle the current
// result is taken. When m_ready is low the output holds, the queue fills
// and s_ready drops once it holds two tokens.
// Reset (aresetn low, synchronous) returns to line start, clears counters
// and errors, empties the queue and sets the separator to a comma.
// ----------------------------------------------------------------------------
module csv_record_tokenizer
    import csvt_pkg::*;
#(
    parameter int FIELD_COUNT_BITS  = 16,
    parameter int RECORD_COUNT_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data
);

    logic [7:0] separator_reg;
    logic       push_valid;
    logic       push_ready;
    token_t     push_data;
    logic       tok_valid;
    logic       tok_ready;
    token_t     tok_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg <= SEP_RESET;
        end else if (cfg_we) begin
            separator_reg <= cfg_wdata;
        end
    end

    csvt_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .separator  (separator_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    csvt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (tok_valid),
        .pop_ready  (tok_ready),
        .pop_data   (tok_data)
    );

    csvt_back #(
        .FIELD_COUNT_BITS  (FIELD_COUNT_BITS),
        .RECORD_COUNT_BITS (RECORD_COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[sim/csv_record_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer_tb
// Self-checking testbench for the CSV record tokenizer.
//
// A short table of hand-made bytes opens the run. Some of its rows carry a
// typed-in expected result and the rest are checked against a behavioral
// tokenizer kept in this bench. Well-formed CSV text follows, in phases that
// each write a separator, with random content, quoting, empty fields
// and blank lines. Both sides of the handshake idle at random in most phases. Errors and
// end of input are sticky until reset, and reset is applied only once, so
// the run ends with one randomly chosen terminating case followed by noise.
// ----------------------------------------------------------------------------
module csv_record_tokenizer_tb;
    import csvt_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int RECORD_FIELDS = 3;

    typedef enum logic [2:0] {
        PM_LINE,
        PM_FSTART,
        PM_QUOTED,
        PM_QQ,
        PM_UNQUOTED,
        PM_DONE
    } pmode_t;

    typedef enum int {
        END_UNTERM,
        END_AFTER_QUOTE,
        END_QUOTE_UNQ,
        END_MISMATCH,
        END_EOF
    } ending_t;

    typedef struct packed {
        in_beat_t  beat;
        logic      typed;
        out_beat_t want;
    } stim_t;

    // rows 1-10 carry their result; the rest go through the predictor
    localparam stim_t DIRECTED [0:24] = '{
        '{'{8'h61, 1'b0}, 1'b1, '{1'b1, 8'h61, 1'b0, 1'b0, 16'd0, 1'b0, ST_OK, 32'd0}},
        '{'{8'h2C, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 16'd1, 1'b0, ST_OK, 32'd0}},
        '{'{8'h2C, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 16'd2, 1'b0, ST_OK, 32'd0}},
        '{'{8'h22, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 16'd2, 1'b0, ST_OK, 32'd0}},
        '{'{8'h22, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 16'd2, 1'b0, ST_OK, 32'd0}},
        '{'{8'h22, 1'b0}, 1'b1, '{1'b1, 8'h22, 1'b0, 1'b0, 16'd2, 1'b0, ST_OK, 32'd0}},
        '{'{8'h22, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 16'd2, 1'b0, ST_OK, 32'd0}},
        '{'{8'h0A, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 16'd3, 1'b0, ST_OK, 32'd0}},
        '{'{8'h0D, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, ST_OK, 32'd1}},
        '{'{8'h0A, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, ST_OK, 32'd1}},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h2C, 1'b0}, 1'b0, '0},
        '{'{8'h22, 1'b0}, 1'b0, '0},
        '{'{8'h0A, 1'b0}, 1'b0, '0},
        '{'{8'h2C, 1'b0}, 1'b0, '0},
        '{'{8'h0D, 1'b0}, 1'b0, '0},
        '{'{8'h22, 1'b0}, 1'b0, '0},
        '{'{8'h2C, 1'b0}, 1'b0, '0},
        '{'{8'h0D, 1'b0}, 1'b0, '0},
        '{'{8'h0A, 1'b0}, 1'b0, '0},
        '{'{8'h2C, 1'b0}, 1'b0, '0},
        '{'{8'h62, 1'b0}, 1'b0, '0},
        '{'{8'h2C, 1'b0}, 1'b0, '0},
        '{'{8'h0A, 1'b0}, 1'b0, '0}
    };

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // tokenizer state as seen by the bench
    logic [7:0]  sep_cfg = SEP_RESET;
    pmode_t      pmode = PM_LINE;
    logic [15:0] fld_cnt = '0;
    logic [15:0] fields_fixed = '0;
    logic        fields_known = 1'b0;
    logic [31:0] rec_cnt = '0;
    logic [2:0]  err_code = ST_OK;

    stim_t     pending_beats[$];
    out_beat_t expected_tokens[$];
    stim_t     cur_beat = '0;
    int        pushed = 0;
    int        mismatch_count = 0;
    int        cycles = 0;
    bit        mid_record = 1'b0;

    int burst_max = 8, gap_max = 0, burst_left = 1, gap_left = 0;
    int stall_pct = 0, hold_left = 0;
    bit hold_req = 1'b0;

    csv_record_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic out_beat_t tokenize_step(in_beat_t b);
        out_beat_t   r;
        cls_t        cls;
        pmode_t      nm;
        logic [2:0]  err;
        logic        cv, fe, re;
        logic [15:0] nf;
        r = '0;
        r.fields_in_record = fld_cnt;
        r.record_index = rec_cnt;
        r.status = err_code;
        r.stream_done = (pmode == PM_DONE);
        if (err_code != ST_OK || pmode == PM_DONE) return r;

        if (b.end_of_input) cls = CLS_EOF;
        else if (b.data_byte == CHAR_CR || b.data_byte == CHAR_LF) cls = CLS_LINE;
        else if (b.data_byte == sep_cfg) cls = CLS_SEP;
        else if (b.data_byte == CHAR_QUOTE) cls = CLS_QUOTE;
        else cls = CLS_OTHER;

        cv = 1'b0;
        fe = 1'b0;
        re = 1'b0;
        nm = pmode;
        err = ST_OK;
        nf = fld_cnt;
        case (pmode)
            PM_LINE, PM_FSTART: begin
                if (cls == CLS_EOF || cls == CLS_LINE) begin
                    if (pmode == PM_FSTART) begin
                        fe = 1'b1;
                        re = 1'b1;
                    end
                    nm = (cls == CLS_EOF) ? PM_DONE : PM_LINE;
                end else if (cls == CLS_SEP) begin
                    fe = 1'b1;
                    nm = PM_FSTART;
                end else if (cls == CLS_QUOTE) begin
                    nm = PM_QUOTED;
                end else begin
                    cv = 1'b1;
                    nm = PM_UNQUOTED;
                end
            end
            PM_QUOTED: begin
                if (cls == CLS_EOF) err = ST_UNTERM;
                else if (cls == CLS_QUOTE) nm = PM_QQ;
                else cv = 1'b1;
            end
            PM_QQ, PM_UNQUOTED: begin
                if (cls == CLS_EOF || cls == CLS_LINE) begin
                    fe = 1'b1;
                    re = 1'b1;
                    nm = (cls == CLS_EOF) ? PM_DONE : PM_LINE;
                end else if (cls == CLS_SEP) begin
                    fe = 1'b1;
                    nm = PM_FSTART;
                end else if (cls == CLS_QUOTE) begin
                    if (pmode == PM_QQ) begin
                        cv = 1'b1;
                        nm = PM_QUOTED;
                    end else begin
                        err = ST_QUOTE_UNQ;
                    end
                end else begin
                    if (pmode == PM_QQ) err = ST_AFTER_QUOTE;
                    else cv = 1'b1;
                end
            end
            default: ;
        endcase

        if (err == ST_OK && fe && nf != 16'hFFFF) nf = nf + 16'd1;
        if (err == ST_OK && re && fields_known && nf != fields_fixed) err = ST_MISMATCH;
        if (err != ST_OK) begin
            err_code = err;
            r.status = err;
            return r;
        end

        pmode = nm;
        r.char_valid = cv;
        r.char_out = cv ? b.data_byte : 8'h00;
        r.field_end = fe;
        r.record_end = re;
        r.fields_in_record = nf;
        r.stream_done = (nm == PM_DONE);
        if (re) begin
            if (!fields_known) begin
                fields_fixed = nf;
                fields_known = 1'b1;
            end
            if (rec_cnt != 32'hFFFF_FFFF) rec_cnt = rec_cnt + 32'd1;
            fld_cnt = '0;
        end else begin
            fld_cnt = nf;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < 40)
            $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_token(out_beat_t got);
        out_beat_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch("beat with nothing expected", got, 0);
            return;
        end
        want = expected_tokens.pop_front();
        if (got.char_valid != want.char_valid)
            report_mismatch("char_valid", got.char_valid, want.char_valid);
        if (got.char_out != want.char_out)
            report_mismatch("char_out", got.char_out, want.char_out);
        if (got.field_end != want.field_end)
            report_mismatch("field_end", got.field_end, want.field_end);
        if (got.record_end != want.record_end)
            report_mismatch("record_end", got.record_end, want.record_end);
        if (got.fields_in_record != want.fields_in_record)
            report_mismatch("fields_in_record", got.fields_in_record, want.fields_in_record);
        if (got.stream_done != want.stream_done)
            report_mismatch("stream_done", got.stream_done, want.stream_done);
        if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
        if (got.record_index != want.record_index)
            report_mismatch("record_index", got.record_index, want.record_index);
    endtask

    // sender: bursts and gaps; predicts each beat as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (cur_beat.typed) begin
                    void'(tokenize_step(cur_beat.beat));
                    expected_tokens.push_back(cur_beat.want);
                end else begin
                    expected_tokens.push_back(tokenize_step(cur_beat.beat));
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    s_data <= cur_beat.beat;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, burst_max);
                        gap_left = $urandom_range(0, gap_max);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 60;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_token(m_data);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_beat(logic [7:0] b, logic eoi);
        stim_t s;
        s = '0;
        s.beat.data_byte = b;
        s.beat.end_of_input = eoi;
        pending_beats.push_back(s);
        pushed++;
    endtask

    task automatic push_byte(logic [7:0] b);
        push_beat(b, 1'b0);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = $urandom_range(0, 255);
        while (b == CHAR_CR || b == CHAR_LF || b == CHAR_QUOTE || b == sep_cfg);
        return b;
    endfunction

    task automatic push_quoted(int len);
        logic [7:0] b;
        push_byte(CHAR_QUOTE);
        repeat (len) begin
            b = $urandom_range(0, 255);
            push_byte(b);
            if (b == CHAR_QUOTE) push_byte(CHAR_QUOTE);
        end
        push_byte(CHAR_QUOTE);
    endtask

    task automatic push_field();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
        if (sep_cfg != CHAR_QUOTE && $urandom_range(0, 2) == 0) begin
            push_quoted(len);
        end else begin
            repeat (len) push_byte(plain_byte());
        end
    endtask

    task automatic push_line_end();
        case ($urandom_range(0, 2))
            0: push_byte(CHAR_LF);
            1: push_byte(CHAR_CR);
            default: begin
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
            end
        endcase
    endtask

    task automatic push_record(int nfields);
        for (int i = 0; i < nfields; i++) begin
            push_field();
            if (i < nfields - 1) push_byte(sep_cfg);
        end
        push_line_end();
    endtask

    task automatic push_blank_lines();
        repeat ($urandom_range(1, 4)) push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    // a separator equal to CR or LF can't split fields: only blank lines and
    // the quoted first field of a record, which the next phase completes
    task automatic gen_line_sep_phase();
        push_blank_lines();
        push_quoted($urandom_range(4, 20));
        mid_record = 1'b1;
    endtask

    task automatic gen_phase(int budget);
        int start;
        start = pushed;
        if (mid_record) begin
            for (int i = 1; i < RECORD_FIELDS; i++) begin
                push_byte(sep_cfg);
                push_field();
            end
            push_line_end();
            mid_record = 1'b0;
        end
        while (pushed - start < budget) begin
            if ($urandom_range(0, 5) == 0) push_blank_lines();
            push_record(RECORD_FIELDS);
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_tokens.size() != 0);
    endtask

    task automatic write_separator(logic [7:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sep_cfg = v;
    endtask

    task automatic gen_ending();
        ending_t kind;
        kind = ending_t'($urandom_range(0, 4));
        case (kind)
            END_UNTERM: begin
                push_byte(CHAR_QUOTE);
                repeat ($urandom_range(0, 4)) push_byte(plain_byte());
                push_beat($urandom_range(0, 255), 1'b1);
            end
            END_AFTER_QUOTE: begin
                push_quoted($urandom_range(0, 3));
                push_byte(plain_byte());
            end
            END_QUOTE_UNQ: begin
                push_byte(plain_byte());
                push_byte(CHAR_QUOTE);
            end
            END_MISMATCH: begin
                push_record(RECORD_FIELDS + $urandom_range(0, 1) * 2 - 1);
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    push_field();
                    push_byte(sep_cfg);
                    push_byte(plain_byte());
                end
                push_beat($urandom_range(0, 255), 1'b1);
            end
        endcase
        repeat (20) push_beat($urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    initial begin
        logic [7:0] seps [0:7];
        logic [7:0] v;
        seps = '{8'h3B, 8'h00, CHAR_LF, 8'hFF, CHAR_QUOTE, CHAR_CR, 8'h09, 8'h7C};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        gap_max = 2;
        stall_pct = 20;
        for (int i = 0; i < 25; i++) begin
            pending_beats.push_back(DIRECTED[i]);
            pushed++;
        end
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 8) begin
                v = seps[ph];
            end else begin
                do v = $urandom_range(0, 255);
                while (v == CHAR_CR || v == CHAR_LF);
            end
            write_separator(v);
            if (ph % 3 == 0) begin
                gap_max = 0;
                stall_pct = 0;
            end else begin
                gap_max = $urandom_range(1, 8);
                stall_pct = $urandom_range(10, 70);
            end
            burst_max = $urandom_range(1, 16);
            if (ph == 1) begin
                gap_max = 0;
                stall_pct = 0;
                hold_req = 1'b1;
            end
            if (v == CHAR_CR || v == CHAR_LF) gen_line_sep_phase();
            else gen_phase(70);
            wait_idle();
        end

        write_separator(SEP_RESET);
        gen_phase(0);
        gen_ending();
        wait_idle();
        repeat (5) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[csv_record_tokenizer.f]
sv/csvt_pkg.sv
sv/csvt_front.sv
sv/csvt_queue.sv
sv/csvt_back.sv
sv/csv_record_tokenizer.sv
sim/csv_record_tokenizer_tb.sv
